>>> rtl/core/conv3x3_image_filter_unit_assert.svh
// Assertion macros used by the filter control module.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef CONV3X3_IMAGE_FILTER_UNIT_ASSERT_SVH
`define CONV3X3_IMAGE_FILTER_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define C3F_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define C3F_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/c3f_pkg.sv
`default_nettype none
package c3f_pkg;

	// Image geometry limits.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_BITS   = $clog2(MAX_WIDTH);
	localparam int W_BITS     = 11;
	localparam int H_BITS     = 13;
	// Rows run on to height plus one while the last row is flushed out.
	localparam int ROW_BITS   = H_BITS;

	// Pixel and arithmetic formats.
	localparam int PIX_LANES      = 3;
	localparam int CHANNELS       = 3;
	localparam int SAMPLE_BITS    = 8;
	localparam int PIX_BITS       = PIX_LANES * SAMPLE_BITS;
	localparam int COEF_BITS      = 20;
	localparam int COEF_FRAC_BITS = 8;
	localparam int KROW_BITS      = 3 * COEF_BITS;
	localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
	localparam int ACC_BITS       = PROD_BITS + 4;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_TOP = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_MID = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_BOT = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH      = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT     = 3'd4;

	typedef logic [PIX_BITS-1:0] pix_t;
	// Window taps indexed [row][column]; column 2 is the newest.
	typedef logic [2:0][2:0][PIX_BITS-1:0] win_t;
	// Kernel rows indexed [row].
	typedef logic [2:0][KROW_BITS-1:0] kern_t;

	// Position flags of one item as it enters the window stage.
	typedef struct packed {
		logic act;
		logic emit;
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
		logic row_end;
		logic frame_end;
	} pos_t;

	// Signed coefficient at kernel row kr, column kc.
	function automatic logic signed [COEF_BITS-1:0] coef(input kern_t kern, input int kr,
			input int kc);
		coef = $signed(kern[kr][COEF_BITS*kc +: COEF_BITS]);
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/conv3x3_image_filter_unit.sv
// Result path: the input word that completes a window moves through the window-stage,
// product and result registers; output pixel k of a frame follows input word k+W+1.
// Throughput: one word per cycle, held back only by the output handshake, which
// stalls the three-stage pipeline as a whole.
// Reset: arst_n clears counters, window taps, valid flags and registers to their
// defaults (width 1024, height 4096, zero kernel); line stores hold no reset value.
`default_nettype none
module conv3x3_image_filter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [23:0]                       s_tdata,  // in_chan0, in_chan1, in_chan2
	input  logic                              s_tuser,  // kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [23:0]                       m_tdata,  // out_chan0, out_chan1, out_chan2
	output logic                              m_tlast,  // row_end
	output logic                              m_tuser,  // frame_end
	input  logic                              cfg_en,
	input  logic [c3f_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [c3f_pkg::KROW_BITS-1:0]     cfg_data
);
	import c3f_pkg::*;

	kern_t               kern_q;
	logic [W_BITS-1:0]   image_width_q;
	logic [H_BITS-1:0]   image_height_q;
	logic [W_BITS-1:0]   w_use;
	logic [H_BITS-1:0]   h_use;
	logic                restart;
	logic                en;
	logic                accept;
	logic                take;
	logic                keep;
	logic [COL_BITS-1:0] x;
	pos_t                pos_s1;
	pix_t                sample;
	win_t                taps_next;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_q         <= '0;
			image_width_q  <= W_BITS'(MAX_WIDTH);
			image_height_q <= H_BITS'(MAX_HEIGHT);
		end else if (cfg_en) begin
			case (cfg_index)
				REG_KERNEL_TOP: kern_q[0] <= cfg_data;
				REG_KERNEL_MID: kern_q[1] <= cfg_data;
				REG_KERNEL_BOT: kern_q[2] <= cfg_data;
				REG_WIDTH:      image_width_q <= cfg_data[W_BITS-1:0];
				REG_HEIGHT:     image_height_q <= cfg_data[H_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign restart = cfg_en && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

	// Image size in use, saturated to the supported range.
	always_comb begin
		if (image_width_q == '0) begin
			w_use = W_BITS'(1);
		end else if (image_width_q > W_BITS'(MAX_WIDTH)) begin
			w_use = W_BITS'(MAX_WIDTH);
		end else begin
			w_use = image_width_q;
		end
		if (image_height_q == '0) begin
			h_use = H_BITS'(1);
		end else if (image_height_q > H_BITS'(MAX_HEIGHT)) begin
			h_use = H_BITS'(MAX_HEIGHT);
		end else begin
			h_use = image_height_q;
		end
	end

	// The pipeline moves whenever the output register is free or being emptied.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign accept   = s_tvalid && en;
	assign sample   = keep ? s_tdata : '0;

	c3f_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.accept  (accept),
		.kind    (s_tuser),
		.restart (restart),
		.w       (w_use),
		.h       (h_use),
		.take    (take),
		.keep    (keep),
		.x       (x),
		.pos_s1  (pos_s1)
	);

	c3f_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.take       (take),
		.x          (x),
		.sample     (sample),
		.clear      (restart),
		.s1_act     (pos_s1.act),
		.s1_restart (pos_s1.frame_end),
		.taps_next  (taps_next)
	);

	c3f_mac u_mac (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.pos_s1        (pos_s1),
		.taps          (taps_next),
		.kern          (kern_q),
		.out_valid     (m_tvalid),
		.out_pix       (m_tdata),
		.out_row_end   (m_tlast),
		.out_frame_end (m_tuser)
	);

endmodule
`default_nettype wire

>>> rtl/core/c3f_ctrl.sv
`default_nettype none
`include "conv3x3_image_filter_unit_assert.svh"
module c3f_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         accept,
	input  logic                         kind,
	input  logic                         restart,
	input  logic [c3f_pkg::W_BITS-1:0]   w,
	input  logic [c3f_pkg::H_BITS-1:0]   h,
	output logic                         take,
	output logic                         keep,
	output logic [c3f_pkg::COL_BITS-1:0] x,
	output c3f_pkg::pos_t                pos_s1
);
	import c3f_pkg::*;

	logic [COL_BITS-1:0] col_q;
	logic [ROW_BITS-1:0] row_q;
	logic [ROW_BITS-1:0] orow;
	logic [W_BITS-1:0]   col_inc;
	logic                in_frame;
	logic                col_is0;
	logic                emit;
	logic                top_ok;
	logic                bot_ok;
	logic                left_ok;
	logic                right_ok;
	logic                row_end;
	logic                frame_end;
	logic                wrap;

	// A flush inside the frame does nothing; anything past the frame pushes zeros.
	assign in_frame = row_q < h;
	assign take     = accept && (!in_frame || !kind);
	assign keep     = in_frame && !kind;
	assign x        = col_q;

	// Position of the output pixel whose window completes with this word.
	assign col_is0   = (col_q == '0);
	assign emit      = (row_q >= ROW_BITS'(2)) || ((row_q == ROW_BITS'(1)) && !col_is0);
	assign orow      = row_q - (col_is0 ? ROW_BITS'(2) : ROW_BITS'(1));
	assign top_ok    = (orow != '0);
	assign bot_ok    = (orow != (h - H_BITS'(1)));
	assign left_ok   = col_is0 ? (w != W_BITS'(1)) : (col_q != COL_BITS'(1));
	assign right_ok  = !col_is0;
	assign row_end   = emit && !right_ok;
	assign frame_end = row_end && !bot_ok;

	assign col_inc = W_BITS'(col_q) + W_BITS'(1);
	assign wrap    = (col_inc >= w);

	// Raster counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + ROW_BITS'(1);
			end else begin
				col_q <= col_inc[COL_BITS-1:0];
			end
		end
	end

	// Flags travel with the word into the window stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_s1 <= '0;
		end else if (en) begin
			pos_s1.act       <= take;
			pos_s1.emit      <= take && emit;
			pos_s1.top_ok    <= top_ok;
			pos_s1.bot_ok    <= bot_ok;
			pos_s1.left_ok   <= left_ok;
			pos_s1.right_ok  <= right_ok;
			pos_s1.row_end   <= take && row_end;
			pos_s1.frame_end <= take && frame_end;
		end
	end

	`C3F_ASSERT_ALWAYS(a_col_in_row, W_BITS'(col_q) < w, "column count reached the row width")
	`C3F_ASSERT_ALWAYS(a_row_bound, (ROW_BITS+1)'(row_q) <= ((ROW_BITS+1)'(h) + (ROW_BITS+1)'(1)), "row count ran past the flush rows")
	`C3F_ASSERT_NEXT(a_restart_clears, restart, (col_q == '0) && (row_q == '0), "size write did not restart the frame")

endmodule
`default_nettype wire

>>> rtl/core/c3f_window.sv
`default_nettype none
module c3f_window (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         take,
	input  logic [c3f_pkg::COL_BITS-1:0] x,
	input  c3f_pkg::pix_t                sample,
	input  logic                         clear,
	input  logic                         s1_act,
	input  logic                         s1_restart,
	output c3f_pkg::win_t                taps_next
);
	import c3f_pkg::*;

	pix_t                up_mem [MAX_WIDTH];
	pix_t                lo_mem [MAX_WIDTH];
	pix_t                up_rd_s1;
	pix_t                lo_rd_s1;
	pix_t                sample_s1;
	logic [COL_BITS-1:0] x_s1;
	win_t                taps_q;

	// Line stores: read both at the column, push the new word into the lower line
	// now and the old lower word into the upper line from the stage-one register. With
	// a one-pixel row the upper read hits that pending write and takes it directly.
	always_ff @(posedge clk) begin
		if (take) begin
			lo_mem[x] <= sample;
			lo_rd_s1  <= lo_mem[x];
			up_rd_s1  <= (s1_act && (x_s1 == x)) ? lo_rd_s1 : up_mem[x];
			sample_s1 <= sample;
			x_s1      <= x;
		end
		if (en && s1_act) begin
			up_mem[x_s1] <= lo_rd_s1;
		end
	end

	// Shifted window for the word in this stage.
	always_comb begin
		for (int tr = 0; tr < 3; tr++) begin
			taps_next[tr][0] = taps_q[tr][1];
			taps_next[tr][1] = taps_q[tr][2];
		end
		taps_next[0][2] = up_rd_s1;
		taps_next[1][2] = lo_rd_s1;
		taps_next[2][2] = sample_s1;
	end

	// Window taps; they clear after the last pixel of a frame and on a size write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= '0;
		end else if (clear) begin
			taps_q <= '0;
		end else if (en && s1_act) begin
			taps_q <= s1_restart ? '0 : taps_next;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/c3f_mac.sv
`default_nettype none
module c3f_mac (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  c3f_pkg::pos_t pos_s1,
	input  c3f_pkg::win_t taps,
	input  c3f_pkg::kern_t kern,
	output logic          out_valid,
	output c3f_pkg::pix_t out_pix,
	output logic          out_row_end,
	output logic          out_frame_end
);
	import c3f_pkg::*;

	logic signed [PROD_BITS-1:0] prod_next [PIX_LANES][3][3];
	logic signed [PROD_BITS-1:0] prod_s2   [PIX_LANES][3][3];
	logic                        valid_s2;
	logic                        row_end_s2;
	logic                        frame_end_s2;
	logic [2:0]                  row_ok;
	logic [2:0]                  col_ok;
	pix_t                        pix_next;
	logic                        valid_q;

	// Taps outside the image get no weight.
	assign row_ok = {pos_s1.bot_ok, 1'b1, pos_s1.top_ok};
	assign col_ok = {pos_s1.right_ok, 1'b1, pos_s1.left_ok};

	// One product per tap and channel; the kernel is applied flipped.
	always_comb begin : prod_calc
		logic signed [PROD_BITS-1:0] cx;
		logic signed [PROD_BITS-1:0] sx;
		for (int ch = 0; ch < PIX_LANES; ch++) begin
			for (int tr = 0; tr < 3; tr++) begin
				for (int tc = 0; tc < 3; tc++) begin
					cx = PROD_BITS'(coef(kern, 2 - tr, 2 - tc));
					sx = $signed({{(PROD_BITS-SAMPLE_BITS){1'b0}},
						taps[tr][tc][SAMPLE_BITS*ch +: SAMPLE_BITS]});
					if (row_ok[tr] && col_ok[tc] && (ch < CHANNELS)) begin
						prod_next[ch][tr][tc] = cx * sx;
					end else begin
						prod_next[ch][tr][tc] = '0;
					end
				end
			end
		end
	end

	// Product stage.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2      <= prod_next;
			row_end_s2   <= pos_s1.row_end;
			frame_end_s2 <= pos_s1.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= pos_s1.emit;
		end
	end

	// Sum, drop the fraction and clamp to the sample range.
	always_comb begin : sum_calc
		logic signed [ACC_BITS-1:0] acc;
		for (int ch = 0; ch < PIX_LANES; ch++) begin
			acc = '0;
			for (int tr = 0; tr < 3; tr++) begin
				for (int tc = 0; tc < 3; tc++) begin
					acc = acc + ACC_BITS'(prod_s2[ch][tr][tc]);
				end
			end
			if (acc[ACC_BITS-1]) begin
				pix_next[SAMPLE_BITS*ch +: SAMPLE_BITS] = '0;
			end else if (|acc[ACC_BITS-1:COEF_FRAC_BITS+SAMPLE_BITS]) begin
				pix_next[SAMPLE_BITS*ch +: SAMPLE_BITS] = '1;
			end else begin
				pix_next[SAMPLE_BITS*ch +: SAMPLE_BITS] =
					acc[COEF_FRAC_BITS +: SAMPLE_BITS];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (en) begin
			out_pix       <= pix_next;
			out_row_end   <= row_end_s2;
			out_frame_end <= frame_end_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_s2;
		end
	end

	assign out_valid = valid_q;

endmodule
`default_nettype wire

>>> bench/conv3x3_image_filter_unit_test.sv
`default_nettype none
module conv3x3_image_filter_unit_test;

	localparam int LINE_DEPTH   = c3f_pkg::MAX_WIDTH;
	localparam int ROW_LIMIT    = c3f_pkg::MAX_HEIGHT;
	localparam int FRAC_BITS    = c3f_pkg::COEF_FRAC_BITS;
	localparam int CBITS        = c3f_pkg::COEF_BITS;
	// Watchdog limit on the length of the whole run.
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int REPORT_MAX   = 10;
	// Pipeline is three stages deep; wait a little longer before touching registers.
	localparam int DRAIN_CYCLES = 8;
	// Input words for the whole run, directed ones included.
	localparam int WORD_TARGET  = 600;
	localparam int LONG_HOLD    = 400;

	localparam logic [c3f_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [23:0] pix;
	} word_t;

	typedef struct packed {
		logic [23:0] chans;
		logic        row_end;
		logic        frame_end;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;  // in_chan0, in_chan1, in_chan2
	logic s_tuser = 1'b0;       // kind
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;       // out_chan0, out_chan1, out_chan2
	logic m_tlast;              // row_end
	logic m_tuser;              // frame_end
	logic cfg_en = 1'b0;
	logic [c3f_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [c3f_pkg::KROW_BITS-1:0] cfg_data = '0;

	conv3x3_image_filter_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock and the single reset at the start.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Filter state mirrored by the predictor.
	logic [23:0] line_up [LINE_DEPTH];
	logic [23:0] line_lo [LINE_DEPTH];
	logic [23:0] taps [3][3];
	logic [c3f_pkg::KROW_BITS-1:0] kern_row [3];
	int img_w;
	int img_h;
	int col_cnt;
	int row_cnt;

	word_t   pixel_q [$];
	result_t filtered_q [$];

	bit offer_live = 1'b0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_left = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int words_sent = 0;

	function automatic int width_in_use();
		if (img_w < 1)
			return 1;
		return (img_w > LINE_DEPTH) ? LINE_DEPTH : img_w;
	endfunction

	function automatic int height_in_use();
		if (img_h < 1)
			return 1;
		return (img_h > ROW_LIMIT) ? ROW_LIMIT : img_h;
	endfunction

	task automatic restart_window();
		int r;
		int c;
		col_cnt = 0;
		row_cnt = 0;
		for (r = 0; r < 3; r++)
			for (c = 0; c < 3; c++)
				taps[r][c] = '0;
	endtask

	task automatic reset_filter_state();
		int i;
		for (i = 0; i < LINE_DEPTH; i++) begin
			line_up[i] = '0;
			line_lo[i] = '0;
		end
		kern_row[0] = '0;
		kern_row[1] = '0;
		kern_row[2] = '0;
		img_w = 1024;
		img_h = 4096;
		restart_window();
	endtask

	task automatic apply_reg_write(input logic [c3f_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [c3f_pkg::KROW_BITS-1:0] data);
		case (idx)
			c3f_pkg::REG_KERNEL_TOP: kern_row[0] = data;
			c3f_pkg::REG_KERNEL_MID: kern_row[1] = data;
			c3f_pkg::REG_KERNEL_BOT: kern_row[2] = data;
			c3f_pkg::REG_WIDTH: begin
				img_w = int'(data[10:0]);
				restart_window();
			end
			c3f_pkg::REG_HEIGHT: begin
				img_h = int'(data[12:0]);
				restart_window();
			end
			default: ;
		endcase
	endtask

	// Advance the window by one accepted word and queue the pixel it completes, if any.
	task automatic filter_step(input word_t wd);
		int wu;
		int hu;
		int x;
		int orow;
		int ocol;
		int r2;
		int c2;
		int ch;
		int tr;
		int tc;
		bit in_frame;
		bit emit;
		logic [23:0] sample;
		logic [23:0] up;
		logic [23:0] lo;
		logic [CBITS-1:0] raw;
		longint acc;
		longint q;
		result_t res;
		wu = width_in_use();
		hu = height_in_use();
		in_frame = row_cnt < hu;
		// A flush inside the frame changes nothing.
		if (wd.kind == KIND_FLUSH && in_frame)
			return;
		sample = (wd.kind == KIND_PIXEL && in_frame) ? wd.pix : '0;
		x = col_cnt;
		up = line_up[x];
		lo = line_lo[x];
		for (tr = 0; tr < 3; tr++) begin
			taps[tr][0] = taps[tr][1];
			taps[tr][1] = taps[tr][2];
		end
		taps[0][2] = up;
		taps[1][2] = lo;
		taps[2][2] = sample;
		line_up[x] = lo;
		line_lo[x] = sample;
		res = '0;
		emit = (row_cnt >= 2) || (row_cnt == 1 && col_cnt >= 1);
		if (emit) begin
			if (col_cnt >= 1) begin
				orow = row_cnt - 1;
				ocol = col_cnt - 1;
			end else begin
				orow = row_cnt - 2;
				ocol = wu - 1;
			end
			for (ch = 0; ch < 3; ch++) begin
				acc = 0;
				for (tr = 0; tr < 3; tr++) begin
					r2 = orow + tr - 1;
					if (r2 >= 0 && r2 < hu) begin
						for (tc = 0; tc < 3; tc++) begin
							c2 = ocol + tc - 1;
							if (c2 >= 0 && c2 < wu) begin
								// Flipped kernel: true convolution.
								raw = kern_row[2 - tr][CBITS * (2 - tc) +: CBITS];
								acc += longint'($signed(raw)) * longint'(taps[tr][tc][8 * ch +: 8]);
							end
						end
					end
				end
				if (acc < 0) begin
					res.chans[8 * ch +: 8] = 8'd0;
				end else begin
					q = acc >>> FRAC_BITS;
					res.chans[8 * ch +: 8] = (q > 255) ? 8'd255 : q[7:0];
				end
			end
			res.row_end = (ocol == wu - 1);
			res.frame_end = res.row_end && (orow == hu - 1);
			filtered_q.push_back(res);
		end
		col_cnt++;
		if (col_cnt >= wu) begin
			col_cnt = 0;
			row_cnt++;
		end
		if (emit && res.frame_end)
			restart_window();
	endtask

	initial reset_filter_state();

	// Driver: take the accepted word and offer the next one at the falling edge.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			filter_step(pixel_q.pop_front());
			offer_live = 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!offer_live) begin
			if (arst_n && pixel_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= pixel_q[0].pix;
				s_tuser <= pixel_q[0].kind;
				offer_live = 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: the receiver's ready, with an occasional long hold-off.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (filtered_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result word: data %h last %b user %b",
						m_tdata, m_tlast, m_tuser);
			end else begin
				want = filtered_q.pop_front();
				if (m_tdata[7:0] !== want.chans[7:0] || m_tdata[15:8] !== want.chans[15:8] ||
						m_tdata[23:16] !== want.chans[23:16] || m_tlast !== want.row_end ||
						m_tuser !== want.frame_end) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("mismatch: expected data %h last %b user %b, got %h %b %b",
							want.chans, want.row_end, want.frame_end, m_tdata, m_tlast, m_tuser);
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [7:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [23:0] rand_pixel();
		return {rand_sample(), rand_sample(), rand_sample()};
	endfunction

	function automatic logic [CBITS-1:0] rand_coef();
		int v;
		case ($urandom_range(0, 5))
			0: return 20'h00000;
			1: return 20'h7FFFF;
			2: return 20'h80000;
			3: return 20'($urandom);
			default: begin
				v = int'($urandom_range(0, 1023)) - 512;
				return v[CBITS-1:0];
			end
		endcase
	endfunction

	function automatic logic [c3f_pkg::KROW_BITS-1:0] rand_kernel_row();
		return {rand_coef(), rand_coef(), rand_coef()};
	endfunction

	task automatic push_word(input logic kind, input logic [23:0] pix);
		pixel_q.push_back({kind, pix});
		words_sent++;
	endtask

	task automatic set_phase(input int p);
		case (p)
			0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
			1: begin src_idle_pct = 47; snk_idle_pct = 0;  end
			2: begin src_idle_pct = 0;  snk_idle_pct = 47; end
			default: begin src_idle_pct = 34; snk_idle_pct = 34; end
		endcase
	endtask

	// Hold the sender until every word is taken, every result is back and the pipe is empty.
	task automatic wait_drained();
		while (pixel_q.size() != 0 || offer_live || filtered_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [c3f_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [c3f_pkg::KROW_BITS-1:0] data);
		@(negedge clk);
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		apply_reg_write(idx, data);
		@(negedge clk);
		cfg_en <= 1'b0;
	endtask

	task automatic set_size(input int w, input int h);
		write_reg(c3f_pkg::REG_WIDTH, 60'(w));
		write_reg(c3f_pkg::REG_HEIGHT, 60'(h));
	endtask

	task automatic write_random_kernel_row();
		case ($urandom_range(0, 2))
			0: write_reg(c3f_pkg::REG_KERNEL_TOP, rand_kernel_row());
			1: write_reg(c3f_pkg::REG_KERNEL_MID, rand_kernel_row());
			default: write_reg(c3f_pkg::REG_KERNEL_BOT, rand_kernel_row());
		endcase
	endtask

	// One frame of pixels and the flush words that push out its last row.
	// With noise: stray flushes, pixels in the flush tail, a kernel change or an abort mid-frame.
	task automatic run_frame(input int w, input int h, input bit new_size, input bit noisy,
			output bit aborted);
		int wu;
		int n;
		int k;
		int cut;
		bit split;
		aborted = 1'b0;
		if (new_size)
			set_size(w, h);
		wu = width_in_use();
		n = wu * height_in_use();
		split = noisy && $urandom_range(0, 5) == 0;
		aborted = noisy && !split && $urandom_range(0, 9) == 0;
		cut = $urandom_range(0, n - 1);
		for (k = 0; k < n; k++) begin
			if (k == cut && (split || aborted)) begin
				wait_drained();
				if (aborted)
					return;
				write_random_kernel_row();
			end
			if (noisy && $urandom_range(0, 19) == 0)
				push_word(KIND_FLUSH, rand_pixel());
			push_word(KIND_PIXEL, rand_pixel());
		end
		for (k = 0; k <= wu; k++) begin
			if (noisy && $urandom_range(0, 5) == 0)
				push_word(KIND_PIXEL, rand_pixel());
			else
				push_word(KIND_FLUSH, rand_pixel());
		end
		if (noisy && $urandom_range(0, 3) == 0)
			push_word(KIND_FLUSH, rand_pixel());
	endtask

	// Stimulus sequence.
	initial begin
		bit need_size;
		bit aborted;
		int frame_no;
		int w;
		int h;
		need_size = 1'b1;
		frame_no = 0;
		@(posedge arst_n);
		@(posedge clk);
		set_phase(0);

		// Directed: extreme coefficients, extreme samples, 3x2 image.
		write_reg(c3f_pkg::REG_KERNEL_TOP, {20'h00100, 20'h80000, 20'h7FFFF});
		write_reg(c3f_pkg::REG_KERNEL_MID, {20'h00000, 20'h00100, 20'hFFF00});
		write_reg(c3f_pkg::REG_KERNEL_BOT, {20'hFFFFF, 20'h00080, 20'h00040});
		write_reg(REG_UNUSED, '1);
		set_size(3, 2);
		push_word(KIND_PIXEL, 24'h000000);
		push_word(KIND_PIXEL, 24'hFFFFFF);
		push_word(KIND_PIXEL, 24'h00FF00);
		// Early flush inside the frame is ignored.
		push_word(KIND_FLUSH, 24'hFFFFFF);
		push_word(KIND_PIXEL, 24'hFF00FF);
		push_word(KIND_PIXEL, 24'h123456);
		push_word(KIND_PIXEL, 24'h80807F);
		push_word(KIND_FLUSH, 24'h000000);
		push_word(KIND_FLUSH, 24'hFFFFFF);
		// A pixel past the frame acts as a flush.
		push_word(KIND_PIXEL, 24'hFFFFFF);
		push_word(KIND_FLUSH, 24'h5A5A5A);
		// Flush after the frame end belongs to the next frame and is ignored.
		push_word(KIND_FLUSH, 24'hA5A5A5);
		wait_drained();

		// Zero sizes saturate to a single pixel.
		set_size(0, 0);
		push_word(KIND_PIXEL, 24'hFFFFFF);
		push_word(KIND_FLUSH, 24'h000000);
		push_word(KIND_FLUSH, 24'h000000);
		wait_drained();

		// Kernel changed in the middle of a 2x2 frame.
		write_reg(c3f_pkg::REG_KERNEL_TOP, '0);
		write_reg(c3f_pkg::REG_KERNEL_BOT, '0);
		set_size(2, 2);
		push_word(KIND_PIXEL, 24'h01FE80);
		push_word(KIND_PIXEL, 24'hFF0001);
		push_word(KIND_PIXEL, 24'h7F8000);
		wait_drained();
		write_reg(c3f_pkg::REG_KERNEL_MID, {20'h00000, 20'h00100, 20'h00000});
		push_word(KIND_PIXEL, 24'h00FFFF);
		push_word(KIND_FLUSH, 24'h000000);
		push_word(KIND_FLUSH, 24'h000000);
		push_word(KIND_FLUSH, 24'h000000);
		wait_drained();

		// Size fields keep only their low bits: a 5x3 frame.
		set_phase(3);
		write_reg(c3f_pkg::REG_KERNEL_TOP, {20'h00020, 20'h00040, 20'h00020});
		write_reg(c3f_pkg::REG_KERNEL_MID, {20'h00040, 20'h00080, 20'hFFFC0});
		write_reg(c3f_pkg::REG_KERNEL_BOT, {20'h00020, 20'h00040, 20'h00020});
		run_frame(32'h805, 32'h2003, 1'b1, 1'b0, aborted);
		wait_drained();

		// Oversized width and height saturate; only the start of such a frame is sent.
		set_size(2047, 8191);
		repeat (8) push_word(KIND_PIXEL, rand_pixel());
		wait_drained();

		// Long receiver hold-off while the sender keeps the input full.
		set_phase(0);
		@(posedge clk);
		hold_left = LONG_HOLD;
		run_frame(16, 6, 1'b1, 1'b0, aborted);
		wait_drained();

		// Random frames, mostly well-formed, with noise and broken frames mixed in.
		while (words_sent < WORD_TARGET) begin
			set_phase((frame_no / 6) % 4);
			if ($urandom_range(0, 2) == 0)
				write_random_kernel_row();
			if ($urandom_range(0, 4) == 0)
				write_random_kernel_row();
			case ($urandom_range(0, 9))
				0: w = 0;
				1: w = 1;
				2, 3: w = $urandom_range(9, 32);
				default: w = $urandom_range(2, 8);
			endcase
			case ($urandom_range(0, 7))
				0: h = 0;
				1: h = 1;
				default: h = $urandom_range(2, 6);
			endcase
			if ($urandom_range(0, 2) != 0)
				need_size = 1'b1;
			run_frame(w, h, need_size, 1'b1, aborted);
			need_size = aborted;
			wait_drained();
			frame_no++;
		end

		wait_drained();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
